// ----- rtl/tdp_pkg.sv -----
// Shared types and constants of the text date parser.
package tdp_pkg;

	localparam int MAX_TEXT_LEN_DEF = 4095;

	localparam int DATE_W = 27;
	localparam int POS_W  = 12;

	// Phase of the scan, one-hot.
	typedef enum logic [4:0] {
		PH_SPACE = 5'b00001,
		PH_FIRST = 5'b00010,
		PH_MONTH = 5'b00100,
		PH_DAY   = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	// Item codes of the func field.
	localparam logic FUNC_CHAR = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	typedef struct packed {
		logic       valid;
		logic       func;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [DATE_W-1:0] date_value;
		logic [POS_W-1:0]  trailer_start;
		logic              length_overflow;
	} result_t;

endpackage

// ----- rtl/tdp_in_if.sv -----
// Character channel: valid, ready and one character word.
interface tdp_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] ch;

	modport source (output valid, output func, output ch, input ready);
	modport sink (input valid, input func, input ch, output ready);
endinterface

// ----- rtl/tdp_out_if.sv -----
// Result channel: valid, ready and one date word.
interface tdp_out_if;
	logic        valid;
	logic        ready;
	logic [26:0] date_value;
	logic [11:0] trailer_start;
	logic        length_overflow;

	modport source (output valid, output date_value, output trailer_start,
		output length_overflow, input ready);
	modport sink (input valid, input date_value, input trailer_start,
		input length_overflow, output ready);
endinterface

// ----- rtl/tdp_in_stage.sv -----
// Input register that holds one accepted character word for the core.
module tdp_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	tdp_in_if.sink        chars,
	input  logic          advance,
	output tdp_pkg::item_t item_s1
);
	import tdp_pkg::*;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] ch_s1;
	logic       take;

	assign chars.ready = !valid_s1 || advance;
	assign take        = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= chars.func;
			ch_s1   <= chars.ch;
		end
	end

	assign item_s1 = '{valid: valid_s1, func: func_s1, ch: ch_s1};

endmodule

// ----- rtl/tdp_core.sv -----
// Scan state and per-character update; builds the result at the end marker.
module tdp_core #(
	parameter int MAX_TEXT_LEN = tdp_pkg::MAX_TEXT_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tdp_pkg::item_t   item_s1,
	input  logic             advance,
	output tdp_pkg::result_t res
);
	import tdp_pkg::*;

	localparam logic [POS_W-1:0] POS_LIMIT =
		(MAX_TEXT_LEN < 4095) ? POS_W'(MAX_TEXT_LEN) : 12'd4095;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [DATE_W-1:0] PIVOT_6 = 27'd780101;
	localparam logic [DATE_W-1:0] BASE_19 = 27'd19000000;
	localparam logic [DATE_W-1:0] BASE_20 = 27'd20000000;

	phase_t              phase_q, phase_d;
	logic [3:0]          len_q, len_d;
	logic [DATE_W-1:0]   first_q, first_d;
	logic [6:0]          month_q, month_d;
	logic [6:0]          day_q, day_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [POS_W-1:0]    gstart_q, gstart_d;
	logic                ovf_q, ovf_d;

	logic                digit, space, dash, is_end;
	logic [3:0]          d;
	logic [DATE_W-1:0]   y_scaled, ym_base, six_val;

	// Outcome of closing the current digit group.
	logic                cl_settle;
	logic [DATE_W-1:0]   cl_value;
	logic [POS_W-1:0]    cl_trailer;
	phase_t              cl_phase;

	assign is_end = (item_s1.func == FUNC_END);
	assign digit  = (item_s1.ch >= CH_ZERO) && (item_s1.ch <= CH_NINE);
	assign d      = digit ? item_s1.ch[3:0] : 4'd0;
	assign space  = (item_s1.ch == CH_BLANK) ||
		((item_s1.ch >= CH_TAB) && (item_s1.ch <= CH_CR));
	assign dash   = !is_end && (item_s1.ch == CH_DASH);

	// The year group has exactly four digits, so fourteen bits hold it.
	assign y_scaled = 27'(first_q[13:0]) * 27'd10000;
	assign ym_base  = y_scaled + 27'(month_q) * 27'd100;
	assign six_val  = first_q + ((first_q < PIVOT_6) ? BASE_20 : BASE_19);

	always_comb begin
		cl_settle  = 1'b1;
		cl_value   = '0;
		cl_trailer = pos_q;
		cl_phase   = PH_DONE;
		unique case (phase_q)
			PH_SPACE: begin
				cl_value = '0;
			end
			PH_FIRST: begin
				if (len_q == 4'd8) begin
					cl_value = first_q;
				end else if (len_q == 4'd6) begin
					cl_value = six_val;
				end else if (len_q == 4'd4) begin
					if (dash) begin
						cl_settle = 1'b0;
						cl_phase  = PH_MONTH;
					end else begin
						cl_value = y_scaled;
					end
				end else begin
					cl_trailer = gstart_q;
				end
			end
			PH_MONTH: begin
				if (len_q == 4'd2) begin
					if (dash) begin
						cl_settle = 1'b0;
						cl_phase  = PH_DAY;
					end else begin
						cl_value = ym_base;
					end
				end else begin
					cl_value = y_scaled;
				end
			end
			PH_DAY: begin
				cl_value = (len_q == 4'd2) ? ym_base + 27'(day_q) : ym_base;
			end
			default: begin
				// Date already decided: keep what is stored.
				cl_value   = first_q;
				cl_trailer = gstart_q;
			end
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		first_d  = first_q;
		month_d  = month_q;
		day_d    = day_q;
		pos_d    = pos_q;
		gstart_d = gstart_q;
		ovf_d    = ovf_q;

		if (advance && !is_end) begin
			unique case (phase_q)
				PH_SPACE: begin
					if (digit) begin
						phase_d  = PH_FIRST;
						gstart_d = pos_q;
						len_d    = 4'd1;
						first_d  = 27'(d);
					end else if (!space) begin
						phase_d  = PH_DONE;
						first_d  = '0;
						gstart_d = pos_q;
					end
				end
				PH_FIRST, PH_MONTH, PH_DAY: begin
					if (digit) begin
						if (phase_q == PH_FIRST && len_q < 4'd8) begin
							first_d = first_q * 27'd10 + 27'(d);
						end
						if (phase_q == PH_MONTH && len_q < 4'd2) begin
							month_d = month_q * 7'd10 + 7'(d);
						end
						if (phase_q == PH_DAY && len_q < 4'd2) begin
							day_d = day_q * 7'd10 + 7'(d);
						end
						if (len_q != 4'd15) begin
							len_d = len_q + 4'd1;
						end
					end else begin
						phase_d = cl_phase;
						if (cl_settle) begin
							first_d  = cl_value;
							gstart_d = cl_trailer;
						end else begin
							len_d = 4'd0;
							if (cl_phase == PH_MONTH) begin
								month_d = '0;
							end else begin
								day_d = '0;
							end
						end
					end
				end
				default: begin
				end
			endcase

			if (pos_q < POS_LIMIT) begin
				pos_d = pos_q + 12'd1;
			end else begin
				ovf_d = 1'b1;
			end
		end else if (advance && is_end) begin
			// The text is finished; start over for the next one.
			phase_d  = PH_SPACE;
			len_d    = '0;
			first_d  = '0;
			month_d  = '0;
			day_d    = '0;
			pos_d    = '0;
			gstart_d = '0;
			ovf_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SPACE;
			len_q    <= '0;
			first_q  <= '0;
			month_q  <= '0;
			day_q    <= '0;
			pos_q    <= '0;
			gstart_q <= '0;
			ovf_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			first_q  <= first_d;
			month_q  <= month_d;
			day_q    <= day_d;
			pos_q    <= pos_d;
			gstart_q <= gstart_d;
			ovf_q    <= ovf_d;
		end
	end

	assign res = '{
		valid:           advance && is_end,
		date_value:      cl_value,
		trailer_start:   cl_trailer,
		length_overflow: ovf_q
	};

endmodule

// ----- rtl/tdp_out_stage.sv -----
// Output register that holds one date word until the sink takes it.
module tdp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  tdp_pkg::result_t res,
	output logic             free,
	tdp_out_if.source        result
);
	import tdp_pkg::*;

	logic              valid_q;
	logic [DATE_W-1:0] date_q;
	logic [POS_W-1:0]  trailer_q;
	logic              ovf_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			date_q    <= res.date_value;
			trailer_q <= res.trailer_start;
			ovf_q     <= res.length_overflow;
		end
	end

	assign result.valid           = valid_q;
	assign result.date_value      = date_q;
	assign result.trailer_start   = trailer_q;
	assign result.length_overflow = ovf_q;

endmodule

// ----- rtl/text_date_parser.sv -----
// A word enters the input register at acceptance and is scanned by the core from that register;
// the date word for an end marker is then registered in the output register.
// Throughput: one character word per cycle, set by the single scan state update in the core,
// except that an end marker waits in the input register, holding the flow, while the output register is full.
// Reset (arst_n low) empties both registers and returns the scan to leading whitespace.
module text_date_parser #(
	parameter int MAX_TEXT_LEN = tdp_pkg::MAX_TEXT_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tdp_in_if.sink    chars,
	tdp_out_if.source result
);
	import tdp_pkg::*;

	item_t   item_s1;
	result_t res;
	logic    out_free;
	logic    advance;

	assign advance = item_s1.valid && (item_s1.func == FUNC_CHAR || out_free);

	tdp_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.advance (advance),
		.item_s1 (item_s1)
	);

	tdp_core #(
		.MAX_TEXT_LEN (MAX_TEXT_LEN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.res     (res)
	);

	tdp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

	// A result is only produced when the output register can take it.
	a_res_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result produced while output register is full");

	// A new date word appears only after an end marker was scanned.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(item_s1.valid && item_s1.func == FUNC_END))
		else $error("date word without an end marker");

	// A reported date never exceeds eight decimal digits.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.date_value <= 27'd99999999)
		else $error("date word out of range");

endmodule

// ----- sim/text_date_parser_tb.sv -----
// Testbench for the text date parser: directed and random texts against a scoreboard with its own scan model.
import tdp_pkg::*;

typedef struct packed {
	logic [DATE_W-1:0] date;
	logic [POS_W-1:0]  trailer;
	logic              saturated;
} date_word_t;

class date_scoreboard;
	localparam int POS_LIMIT    = (MAX_TEXT_LEN_DEF < 4095) ? MAX_TEXT_LEN_DEF : 4095;
	localparam int YY_PIVOT     = 780101;
	localparam int CENTURY_STEP = 1000000;
	localparam int CENTURY_BASE = 19000000;
	localparam int YEAR_SCALE   = 10000;
	localparam int PART_SCALE   = 100;
	localparam logic [7:0] DASH_CHAR  = 8'h2d;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] TAB_CHAR   = 8'h09;
	localparam logic [7:0] CR_CHAR    = 8'h0d;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] NINE_CHAR  = 8'h39;

	phase_t            scan_phase;
	logic [3:0]        run_len;
	logic [DATE_W-1:0] lead_group;
	logic [6:0]        month_val;
	logic [6:0]        day_val;
	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  run_start;
	logic              sat;
	date_word_t        expected_dates[$];
	int                errors;

	function new();
		errors = 0;
		clear_scan();
	endfunction

	function void clear_scan();
		scan_phase = PH_SPACE;
		run_len    = '0;
		lead_group = '0;
		month_val  = '0;
		day_val    = '0;
		pos        = '0;
		run_start  = '0;
		sat        = 1'b0;
	endfunction

	function int waiting();
		return expected_dates.size();
	endfunction

	function void settle(int unsigned value, logic [POS_W-1:0] trailer);
		lead_group = value[DATE_W-1:0];
		run_start  = trailer;
		scan_phase = PH_DONE;
	endfunction

	// A digit run ends here; dash tells whether the character ending it is a dash.
	function void close_run(bit dash);
		int unsigned y;
		int unsigned ym;
		int unsigned n;
		y  = 32'(lead_group);
		ym = (y * PART_SCALE + month_val) * PART_SCALE;
		case (scan_phase)
			PH_SPACE: settle(0, pos);
			PH_FIRST: begin
				if (run_len == 4'd8) begin
					settle(32'(lead_group), pos);
				end else if (run_len == 4'd6) begin
					n = 32'(lead_group);
					if (n < YY_PIVOT)
						n += CENTURY_STEP;
					settle(n + CENTURY_BASE, pos);
				end else if (run_len == 4'd4) begin
					if (dash) begin
						scan_phase = PH_MONTH;
						run_len    = '0;
						month_val  = '0;
					end else begin
						settle(y * YEAR_SCALE, pos);
					end
				end else begin
					settle(0, run_start);
				end
			end
			PH_MONTH: begin
				if (run_len == 4'd2) begin
					if (dash) begin
						scan_phase = PH_DAY;
						run_len    = '0;
						day_val    = '0;
					end else begin
						settle(ym, pos);
					end
				end else begin
					settle(y * YEAR_SCALE, pos);
				end
			end
			PH_DAY: begin
				if (run_len == 4'd2)
					settle(ym + day_val, pos);
				else
					settle(ym, pos);
			end
			default: ;
		endcase
	endfunction

	function void note_word(logic func, logic [7:0] ch);
		bit         digit;
		logic [3:0] d;
		date_word_t w;
		digit = (ch >= ZERO_CHAR) && (ch <= NINE_CHAR);
		d     = digit ? 4'(ch - ZERO_CHAR) : 4'd0;
		if (func == FUNC_END) begin
			close_run(1'b0);
			w.date      = lead_group;
			w.trailer   = run_start;
			w.saturated = sat;
			expected_dates.push_back(w);
			clear_scan();
			return;
		end
		case (scan_phase)
			PH_SPACE: begin
				if (!(ch == SPACE_CHAR || (ch >= TAB_CHAR && ch <= CR_CHAR))) begin
					if (digit) begin
						scan_phase = PH_FIRST;
						run_start  = pos;
						run_len    = 4'd1;
						lead_group = DATE_W'(d);
					end else begin
						settle(0, pos);
					end
				end
			end
			PH_FIRST: begin
				if (digit) begin
					if (run_len < 4'd8)
						lead_group = DATE_W'(lead_group * 10 + d);
					if (run_len < 4'd15)
						run_len++;
				end else begin
					close_run(ch == DASH_CHAR);
				end
			end
			PH_MONTH, PH_DAY: begin
				if (digit) begin
					if (run_len < 4'd2) begin
						if (scan_phase == PH_MONTH)
							month_val = 7'(month_val * 10 + d);
						else
							day_val = 7'(day_val * 10 + d);
					end
					if (run_len < 4'd15)
						run_len++;
				end else begin
					close_run(ch == DASH_CHAR);
				end
			end
			default: ;
		endcase
		if (pos < POS_LIMIT)
			pos++;
		else
			sat = 1'b1;
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		if (errors < 40)
			$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	task check_result(logic [DATE_W-1:0] date, logic [POS_W-1:0] trailer, logic saturated);
		date_word_t w;
		if (expected_dates.size() == 0) begin
			report("date word with none expected", 32'(date), 0);
			return;
		end
		w = expected_dates.pop_front();
		if (date !== w.date)
			report("date_value", 32'(date), 32'(w.date));
		if (trailer !== w.trailer)
			report("trailer_start", 32'(trailer), 32'(w.trailer));
		if (saturated !== w.saturated)
			report("length_overflow", 32'(saturated), 32'(w.saturated));
	endtask
endclass

module text_date_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET   = 1600;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [7:0] DASH_CHAR  = 8'h2d;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] TAB_CHAR   = 8'h09;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;

	logic clk;
	logic arst_n;

	tdp_in_if  chars();
	tdp_out_if result();

	text_date_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result)
	);

	date_scoreboard sb;
	logic [7:0]     text_buf[$];
	int             burst_left;
	int unsigned    cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL text_date_parser");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
			sb.check_result(result.date_value, result.trailer_start, result.length_overflow);
	end

	// Receiver: runs of steady ready, short stalls, random and toggling ready.
	initial begin
		int mode;
		int span;
		result.ready <= 1'b0;
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = (mode == 1) ? $urandom_range(1, 12) : $urandom_range(1, 30);
			repeat (span) begin
				case (mode)
					0: result.ready <= 1'b1;
					1: result.ready <= 1'b0;
					2: result.ready <= 1'($urandom_range(0, 1));
					default: result.ready <= ~result.ready;
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic logic [7:0] blank_char();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? SPACE_CHAR : TAB_CHAR + 8'(k);
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 3))
			0: return ZERO_CHAR + 8'($urandom_range(0, 9));
			1: return DASH_CHAR;
			2: return blank_char();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void push_digits(int n);
		repeat (n) text_buf.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void push_number(int unsigned v, int n);
		int unsigned scale;
		scale = 1;
		repeat (n - 1) scale *= 10;
		repeat (n) begin
			text_buf.push_back(ZERO_CHAR + 8'((v / scale) % 10));
			scale /= 10;
		end
	endfunction

	// Mostly two digits, with short and long runs for month and day.
	function automatic int part_len();
		int k;
		k = $urandom_range(0, 9);
		if (k <= 1)
			return k;
		if (k <= 6)
			return 2;
		if (k == 7)
			return 3;
		return (k == 8) ? $urandom_range(4, 8) : $urandom_range(9, 17);
	endfunction

	function automatic void build_text();
		int          form;
		int          n;
		logic [7:0]  c;
		text_buf.delete();
		repeat ($urandom_range(0, 3)) text_buf.push_back(blank_char());
		form = $urandom_range(0, 11);
		case (form)
			0, 1: begin
				if ($urandom_range(0, 5) == 0)
					push_number($urandom_range(0, 1) ? 99999999 : 0, 8);
				else
					push_digits(8);
			end
			2, 3: begin
				if ($urandom_range(0, 2) == 0)
					push_number($urandom_range(780095, 780106), 6);
				else
					push_number($urandom_range(0, 999999), 6);
			end
			4, 5, 6: begin
				push_digits(4);
				if ($urandom_range(0, 3) != 0) begin
					text_buf.push_back(DASH_CHAR);
					push_digits(part_len());
					if ($urandom_range(0, 2) != 0) begin
						text_buf.push_back(DASH_CHAR);
						push_digits(part_len());
					end
				end
			end
			7: begin
				do
					n = $urandom_range(1, 20);
				while (n == 4 || n == 6 || n == 8);
				push_digits(n);
			end
			8: begin
				do
					c = 8'($urandom_range(0, 255));
				while ((c >= ZERO_CHAR && c <= ZERO_CHAR + 8'd9) || c == SPACE_CHAR ||
					(c >= TAB_CHAR && c <= TAB_CHAR + 8'd4));
				text_buf.push_back(c);
			end
			9: ;
			default: repeat ($urandom_range(0, 12)) text_buf.push_back(noise_char());
		endcase
		if (form != 9)
			repeat ($urandom_range(0, 6)) text_buf.push_back(noise_char());
	endfunction

	task automatic send_word(logic func, logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				chars.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) :
				$urandom_range(1, 16);
		end
		burst_left--;
		chars.valid <= 1'b1;
		chars.func  <= func;
		chars.ch    <= ch;
		do
			@(posedge clk);
		while (chars.ready !== 1'b1);
		sb.note_word(func, ch);
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_word(FUNC_CHAR, text_buf[i]);
		send_word(FUNC_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_string(string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_text();
	endtask

	task automatic hold_until_drained();
		chars.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.waiting() != 0);
	endtask

	initial begin
		int text_no;
		int items_sent;
		int target;
		sb          = new();
		burst_left  = 0;
		text_no     = 0;
		items_sent  = 0;
		arst_n      <= 1'b0;
		chars.valid <= 1'b0;
		chars.func  <= FUNC_CHAR;
		chars.ch    <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Empty text, six-digit pivot, full year-month-day, and the byte extremes.
		send_string("");
		send_string("780100");
		send_string("1999-12-31");
		text_buf.delete();
		text_buf.push_back(8'h0b);
		text_buf.push_back(8'hff);
		send_text();
		text_buf.delete();
		text_buf.push_back(8'h00);
		send_text();

		while (items_sent < ITEM_TARGET) begin
			text_no++;
			build_text();
			if (text_no % 40 == 0) begin
				// Texts around the length where the position counter saturates.
				if (text_no % 80 == 0) begin
					target = $urandom_range(4093, 4100);
					while (text_buf.size() < target)
						text_buf.push_back(noise_char());
				end else begin
					repeat ($urandom_range(4090, 4100)) text_buf.push_front(blank_char());
				end
			end
			items_sent += text_buf.size() + 1;
			send_text();
			if (text_no % 25 == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.waiting() != 0)
			sb.report("date words never delivered", sb.waiting(), 0);
		if (sb.errors == 0)
			$display("PASS text_date_parser");
		else
			$display("FAIL text_date_parser");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/tdp_pkg.sv
rtl/tdp_in_if.sv
rtl/tdp_out_if.sv
rtl/tdp_in_stage.sv
rtl/tdp_core.sv
rtl/tdp_out_stage.sv
rtl/text_date_parser.sv
sim/text_date_parser_tb.sv
